>>> rtl/nearest_palette_color_assert.svh
// ----------------------------------------------------------------------------
// nearest_palette_color assertion macros
// Shared property forms for the palette search checks.
// ----------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOR_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_ASSERT_SVH

// condition holds at every edge out of reset
`define NPC_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("palette search check failed");

// antecedent implies consequent on the next edge
`define NPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("palette search sequence check failed");

`endif

>>> rtl/npc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npc_pkg
// Types, channel levels and the palette contents as level codes.
// ----------------------------------------------------------------------------
package npc_pkg;

  localparam int ROM_DEPTH  = 256;
  localparam int TREE_DEPTH = 8;
  localparam int STD_COUNT  = 16;
  localparam int CUBE_SIDE  = 6;
  localparam int CUBE_END   = 232;
  localparam int LEVELS     = 8;
  localparam int DIST_W     = 18;

  typedef logic [7:0]        chan_t;
  typedef logic [2:0]        code_t;
  typedef logic [15:0]       sq_t;
  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [7:0]        idx_t;

  typedef sq_t   [LEVELS-1:0] lvl_sq_t;
  typedef lvl_sq_t [2:0]      pix_sq_t;

  typedef struct packed {
    code_t r;
    code_t g;
    code_t b;
  } entry_code_t;

  // every channel value used anywhere in the palette
  localparam chan_t LEVEL [LEVELS] = '{
    8'd0, 8'd51, 8'd85, 8'd102, 8'd153, 8'd170, 8'd204, 8'd255
  };

  localparam code_t L_0   = 3'd0;
  localparam code_t L_85  = 3'd2;
  localparam code_t L_170 = 3'd5;
  localparam code_t L_255 = 3'd7;

  localparam entry_code_t STD_CODES [STD_COUNT] = '{
    '{L_0,   L_0,   L_0},   '{L_0,   L_0,   L_170},
    '{L_0,   L_170, L_0},   '{L_0,   L_170, L_170},
    '{L_170, L_0,   L_0},   '{L_170, L_0,   L_170},
    '{L_170, L_85,  L_0},   '{L_170, L_170, L_170},
    '{L_85,  L_85,  L_85},  '{L_85,  L_85,  L_255},
    '{L_85,  L_255, L_85},  '{L_85,  L_255, L_255},
    '{L_255, L_85,  L_85},  '{L_255, L_85,  L_255},
    '{L_255, L_255, L_85},  '{L_255, L_255, L_255}
  };

  // cube steps 0, 51, 102, 153, 204, 255
  localparam code_t CUBE_CODES [CUBE_SIDE] = '{
    3'd0, 3'd1, 3'd3, 3'd4, 3'd6, 3'd7
  };

  function automatic entry_code_t entry_code(input int unsigned idx);
    entry_code_t c;
    int unsigned n;
    c = '{L_0, L_0, L_0};
    n = STD_COUNT;
    if (idx < STD_COUNT) begin
      c = STD_CODES[idx];
    end else begin
      for (int r = 0; r < CUBE_SIDE; r++) begin
        for (int g = 0; g < CUBE_SIDE; g++) begin
          for (int b = 0; b < CUBE_SIDE; b++) begin
            if (n == idx) begin
              c = '{CUBE_CODES[r], CUBE_CODES[g], CUBE_CODES[b]};
            end
            n++;
          end
        end
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/npc_sqdiff.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npc_sqdiff
// Registers the pixel, then the squared distance of each channel to every
// palette level.
// ----------------------------------------------------------------------------
module npc_sqdiff (
  input  logic             clk,
  input  logic             en,
  input  npc_pkg::chan_t   red,
  input  npc_pkg::chan_t   green,
  input  npc_pkg::chan_t   blue,
  output npc_pkg::pix_sq_t sq
);
  import npc_pkg::*;

  chan_t   px [3];
  chan_t   df [3][LEVELS];
  pix_sq_t sq_next;

  always_ff @(posedge clk) begin
    if (en) begin
      px[0] <= red;
      px[1] <= green;
      px[2] <= blue;
      sq    <= sq_next;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int l = 0; l < LEVELS; l++) begin
        df[c][l] = (px[c] >= LEVEL[l]) ? (px[c] - LEVEL[l]) : (LEVEL[l] - px[c]);
        sq_next[c][l] = sq_t'(16'(df[c][l]) * 16'(df[c][l]));
      end
    end
  end

endmodule

>>> rtl/npc_dist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npc_dist
// Sums the three channel terms of each searched palette entry.
// ----------------------------------------------------------------------------
module npc_dist #(
  parameter int NUM = 232
) (
  input  logic                       clk,
  input  logic                       en,
  input  npc_pkg::pix_sq_t           sq,
  output npc_pkg::dist_t [NUM-1:0]   edist
);
  import npc_pkg::*;

  for (genvar e = 0; e < NUM; e++) begin : g_entry
    localparam entry_code_t C = entry_code(e);
    dist_t edist_next;

    assign edist_next = dist_t'(sq[0][C.r]) + dist_t'(sq[1][C.g]) + dist_t'(sq[2][C.b]);

    always_ff @(posedge clk) begin
      if (en) begin
        edist[e] <= edist_next;
      end
    end
  end

endmodule

>>> rtl/npc_min_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npc_min_tree
// Binary minimum tree over the entry distances, registered every two
// levels; the left child wins ties so the lowest index survives.
// ----------------------------------------------------------------------------
module npc_min_tree #(
  parameter int NUM = 232
) (
  input  logic                     clk,
  input  logic                     en,
  input  npc_pkg::dist_t [NUM-1:0] edist,
  output npc_pkg::idx_t            palette_index
);
  import npc_pkg::*;

  localparam int NODES = 2 * ROM_DEPTH;

  dist_t od [1:NODES-1];
  idx_t  oi [1:NODES-1];
  dist_t cd [1:ROM_DEPTH-1];
  idx_t  ci [1:ROM_DEPTH-1];
  dist_t rd [1:ROM_DEPTH-1];
  idx_t  ri [1:ROM_DEPTH-1];

  // leaves past the searched range never win
  for (genvar i = 0; i < ROM_DEPTH; i++) begin : g_leaf
    if (i < NUM) begin : g_used
      assign od[ROM_DEPTH + i] = edist[i];
    end else begin : g_pad
      assign od[ROM_DEPTH + i] = '1;
    end
    assign oi[ROM_DEPTH + i] = idx_t'(i);
  end

  for (genvar k = 1; k < ROM_DEPTH; k++) begin : g_node
    localparam int DEPTH = $clog2(k + 1) - 1;
    logic take_right;

    assign take_right = od[2*k+1] < od[2*k];
    assign cd[k] = take_right ? od[2*k+1] : od[2*k];
    assign ci[k] = take_right ? oi[2*k+1] : oi[2*k];

    if ((TREE_DEPTH - DEPTH) % 2 == 0) begin : g_reg
      always_ff @(posedge clk) begin
        if (en) begin
          rd[k] <= cd[k];
          ri[k] <= ci[k];
        end
      end
      assign od[k] = rd[k];
      assign oi[k] = ri[k];
    end else begin : g_comb
      assign od[k] = cd[k];
      assign oi[k] = ci[k];
    end
  end

  assign palette_index = oi[1];

endmodule

>>> rtl/nearest_palette_color.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_palette_color
// Nearest palette entry search for one RGB pixel per beat.
// ----------------------------------------------------------------------------
// Input beats arrive on s_tvalid/s_tready/s_tdata with red in bits 7:0,
// green in 15:8 and blue in 23:16. Each input beat yields one output beat
// on m_tvalid/m_tready/m_tdata carrying the index of the nearest palette
// entry by squared distance, lowest index on a tie.
// The pipeline from acceptance to m_tvalid runs through the pixel register,
// per-level channel squares, per-entry sums, then four stages of the
// minimum tree, each covering two compare levels.
// Throughput is one pixel per cycle unless the receiver stalls; the whole
// pipeline advances as one, so s_tready is high whenever the output
// register is empty or drained. When the receiver stalls, every stage
// holds and s_tready drops; nothing is lost or repeated. Reset empties the
// pipeline; the palette is constant and needs no loading.
// PALETTE_SIZE sets how many entries from index 0 take part; at most 232 are searched.
// ----------------------------------------------------------------------------
module nearest_palette_color #(
  parameter int PALETTE_SIZE = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red, green, blue
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // palette_index
);
  import npc_pkg::*;

  // black tail entries equal entry 0 and can never win
  localparam int NUM_SEARCH = (PALETTE_SIZE < CUBE_END) ? PALETTE_SIZE : CUBE_END;
  localparam int STAGES     = 7;

  logic              en;
  logic [STAGES-1:0] vld;
  pix_sq_t           sq;
  dist_t [NUM_SEARCH-1:0] edist;
  idx_t              palette_index;

  assign en       = ~vld[STAGES-1] | m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[STAGES-1];
  assign m_tdata  = palette_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], s_tvalid};
    end
  end

  npc_sqdiff u_sqdiff (
    .clk   (clk),
    .en    (en),
    .red   (s_tdata[7:0]),
    .green (s_tdata[15:8]),
    .blue  (s_tdata[23:16]),
    .sq    (sq)
  );

  npc_dist #(
    .NUM (NUM_SEARCH)
  ) u_dist (
    .clk   (clk),
    .en    (en),
    .sq    (sq),
    .edist (edist)
  );

  npc_min_tree #(
    .NUM (NUM_SEARCH)
  ) u_min_tree (
    .clk           (clk),
    .en            (en),
    .edist         (edist),
    .palette_index (palette_index)
  );

`include "nearest_palette_color_assert.svh"

  `NPC_ASSERT_ALWAYS(a_index_range, !m_tvalid || ({1'b0, m_tdata} < 9'(NUM_SEARCH)))
  `NPC_ASSERT_NEXT(a_stall_holds, !s_tready, $stable(vld))
  `NPC_ASSERT_NEXT(a_stage_feeds_out, s_tready && vld[STAGES-2], m_tvalid)

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Streams RGB pixels through nearest_palette_color and checks every returned
// palette index against an in-bench nearest-colour search over the palette,
// with random gaps on both sides, a long output hold-off and a full drain.
// ----------------------------------------------------------------------------
module tb;

  localparam int SEARCH_SIZE = 256;
  localparam int ROM_ENTRIES = 256;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 20;

  typedef struct {
    npc_pkg::chan_t red;
    npc_pkg::chan_t green;
    npc_pkg::chan_t blue;
  } pixel_t;

  localparam logic [23:0] STD_RGB [16] = '{
    24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
    24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
    24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
    24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
  };

  localparam npc_pkg::chan_t EDGE_VALS [16] = '{
    8'd25, 8'd26, 8'd42, 8'd43, 8'd93, 8'd94, 8'd127, 8'd128,
    8'd161, 8'd162, 8'd186, 8'd187, 8'd212, 8'd213, 8'd229, 8'd230
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;

  pixel_t         pixel_q[$];
  npc_pkg::idx_t  index_q[$];
  int unsigned    n_queued = 0;
  int unsigned    n_taken = 0;
  int unsigned    errors = 0;
  int unsigned    quiet_cycles = 0;
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_idle_pct = 0;
  logic           hold_go = 1'b0;
  logic           hold_done = 1'b0;
  int unsigned    hold_left = 0;

  nearest_palette_color #(.PALETTE_SIZE(SEARCH_SIZE)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // red, green, blue
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // palette_index
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [23:0] palette_rgb(input int unsigned idx);
    int unsigned k;
    logic [23:0] c;
    c = '0;
    if (idx < 16) begin
      c = STD_RGB[idx];
    end else if (idx < 232) begin
      k = idx - 16;
      c[23:16] = 8'((k / 36) * 51);
      c[15:8]  = 8'(((k / 6) % 6) * 51);
      c[7:0]   = 8'((k % 6) * 51);
    end
    return c;
  endfunction

  function automatic npc_pkg::idx_t nearest_index(input npc_pkg::chan_t r,
                                                  input npc_pkg::chan_t g,
                                                  input npc_pkg::chan_t b);
    int unsigned best;
    int unsigned best_dist;
    int unsigned d;
    int unsigned span;
    int dr, dg, db;
    logic [23:0] c;
    best = 0;
    best_dist = 32'hFFFF_FFFF;
    span = (SEARCH_SIZE > ROM_ENTRIES) ? ROM_ENTRIES : SEARCH_SIZE;
    for (int unsigned i = 0; i < span; i++) begin
      c = palette_rgb(i);
      dr = int'(r) - int'(c[23:16]);
      dg = int'(g) - int'(c[15:8]);
      db = int'(b) - int'(c[7:0]);
      d = dr * dr + dg * dg + db * db;
      if (d < best_dist) begin
        best_dist = d;
        best = i;
      end
    end
    return npc_pkg::idx_t'(best);
  endfunction

  function automatic npc_pkg::chan_t jitter(input npc_pkg::chan_t v);
    int x;
    x = int'(v) + int'($urandom_range(12)) - 6;
    if (x < 0) x = 0;
    if (x > 255) x = 255;
    return npc_pkg::chan_t'(x);
  endfunction

  task automatic add_pixel(input npc_pkg::chan_t r, input npc_pkg::chan_t g,
                           input npc_pkg::chan_t b);
    pixel_t p;
    p.red = r;
    p.green = g;
    p.blue = b;
    pixel_q.push_back(p);
    n_queued++;
  endtask

  task automatic add_random(input int unsigned count);
    int unsigned pick;
    logic [23:0] c;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        add_pixel(npc_pkg::chan_t'($urandom_range(255)),
                  npc_pkg::chan_t'($urandom_range(255)),
                  npc_pkg::chan_t'($urandom_range(255)));
      end else if (pick < 85) begin
        c = palette_rgb($urandom_range(231));
        add_pixel(jitter(c[23:16]), jitter(c[15:8]), jitter(c[7:0]));
      end else begin
        add_pixel(EDGE_VALS[$urandom_range(15)], EDGE_VALS[$urandom_range(15)],
                  EDGE_VALS[$urandom_range(15)]);
      end
    end
  endtask

  // sender: keep a beat on offer until taken, gaps at random
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= {pixel_q[0].blue, pixel_q[0].green, pixel_q[0].red};
        void'(pixel_q.pop_front());
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, one long hold-off on request
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (index_q.size() == 0) begin
          $display("%0t: unexpected beat, actual index %0d", $time, m_tdata);
          errors++;
        end else begin
          if (m_tdata !== index_q[0]) begin
            $display("%0t: palette_index mismatch, expected %0d actual %0d",
                     $time, index_q[0], m_tdata);
            errors++;
          end
          void'(index_q.pop_front());
        end
      end
      if (s_tvalid && s_tready) begin
        index_q.push_back(nearest_index(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]));
        n_taken++;
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
        $display("tb NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [23:0] c;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // channel extremes, exact palette colours, black tail and tie points
    add_pixel(8'd0, 8'd0, 8'd0);
    add_pixel(8'd255, 8'd255, 8'd255);
    add_pixel(8'd255, 8'd0, 8'd0);
    add_pixel(8'd0, 8'd255, 8'd0);
    add_pixel(8'd0, 8'd0, 8'd255);
    add_pixel(8'd1, 8'd2, 8'd4);
    add_pixel(8'd254, 8'd253, 8'd251);
    add_pixel(8'd128, 8'd127, 8'd128);
    for (int i = 1; i < 16; i += 2) begin
      c = STD_RGB[i];
      add_pixel(c[23:16], c[15:8], c[7:0]);
    end
    add_pixel(8'd85, 8'd85, 8'd85);
    c = palette_rgb(231);
    add_pixel(c[23:16], c[15:8], c[7:0]);
    c = palette_rgb(100);
    add_pixel(c[23:16], c[15:8], c[7:0]);
    add_pixel(8'd25, 8'd26, 8'd25);
    add_pixel(8'd42, 8'd43, 8'd128);
    add_pixel(8'd93, 8'd161, 8'd212);

    send_idle_pct = 19;
    recv_idle_pct = 59;
    add_random(280);
    wait (n_taken == n_queued && index_q.size() == 0);

    send_idle_pct = 59;
    recv_idle_pct = 19;
    add_random(280);
    wait (n_taken == n_queued && index_q.size() == 0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random(290);
    hold_go <= 1'b1;
    wait (n_taken == n_queued && index_q.size() == 0);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (index_q.size() != 0) begin
      $display("%0t: %0d indices never arrived", $time, index_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
